FILE: sv/anb_pkg.sv
`default_nettype none

package anb_pkg;

	// Field widths
	localparam int BYTE_W = 8;
	localparam int CNT_W = 23;
	localparam int TYPE_W = 5;
	localparam int WIN_W = 3 * BYTE_W;

	// Counter limit and framing constants
	localparam logic [CNT_W-1:0] FRAME_BYTES_MAX = CNT_W'(4194304);
	localparam logic [CNT_W-1:0] SLOT_BYTES = CNT_W'(4);
	// header slot plus the start code that ends the NAL
	localparam logic [CNT_W-1:0] SLOT_PAIR = CNT_W'(2 * SLOT_BYTES);
	localparam logic [BYTE_W-1:0] SC_LAST_BYTE = 8'h01;
	localparam logic [WIN_W-1:0] WIN_RESET = '1;

	// NAL unit type codes
	localparam logic [TYPE_W-1:0] TYPE_SPS = 5'h07;
	localparam logic [TYPE_W-1:0] TYPE_AUD = 5'h09;

	// Event kinds
	localparam logic EV_NAL = 1'b0;
	localparam logic EV_FRAME = 1'b1;

	// Results one byte can cause, and the result queue
	localparam int RES_MAX = 3;
	localparam int RES_CNT_W = $clog2(RES_MAX + 1);
	localparam int Q_DEPTH = 8;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
	// one item in the input stage and one newly accepted may each push RES_MAX
	localparam int Q_ACCEPT_MAX = Q_DEPTH - 2 * RES_MAX;

	typedef struct packed {
		logic event_kind;
		logic [CNT_W-1:0] nal_length;
		logic [TYPE_W-1:0] unit_type;
		logic [CNT_W-1:0] frame_size;
		logic is_key;
		logic last_of_run;
	} anb_result_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0] cnt;
		anb_result_t [RES_MAX-1:0] res;
	} anb_push_t;

endpackage

`default_nettype wire

FILE: sv/anb_in_if.sv
`default_nettype none

interface anb_in_if import anb_pkg::*;;
	logic valid;
	logic ready;
	logic [BYTE_W-1:0] data_byte;
	logic end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

FILE: sv/anb_out_if.sv
`default_nettype none

interface anb_out_if import anb_pkg::*;;
	logic valid;
	logic ready;
	logic event_kind;
	logic [CNT_W-1:0] nal_length;
	logic [TYPE_W-1:0] unit_type;
	logic [CNT_W-1:0] frame_size;
	logic is_key;
	logic last_of_run;

	modport source (output valid, output event_kind, output nal_length, output unit_type,
		output frame_size, output is_key, output last_of_run, input ready);
	modport sink (input valid, input event_kind, input nal_length, input unit_type,
		input frame_size, input is_key, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: sv/anb_parse.sv
`default_nettype none

module anb_parse import anb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic [BYTE_W-1:0] data_byte,
	input wire logic end_of_stream,
	output anb_push_t push
);

	logic valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic eos_s1;

	logic [WIN_W-1:0] win_q;
	logic [CNT_W-1:0] nal_cnt_q, frm_cnt_q;
	logic awaiting_q, key_q, code_led_q;
	logic [TYPE_W-1:0] type_q;

	logic [CNT_W-1:0] nal1, frm1, frm2, nal2, fs_aud, nl_sc, nl_eos;
	logic take_type, is_aud, is_sps, emit_aud, is_sc, emit_sc, key1, awaiting1;
	logic [TYPE_W-1:0] type1;
	anb_result_t r_aud, r_sc, r_eos_nal, r_eos_frm;
	anb_result_t [RES_MAX-1:0] list;
	logic [RES_CNT_W-1:0] k;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			eos_s1 <= end_of_stream;
		end
	end

	// Counters, type capture, frame delimiter
	always_comb begin
		nal1 = (nal_cnt_q >= FRAME_BYTES_MAX) ? FRAME_BYTES_MAX : nal_cnt_q + CNT_W'(1);
		frm1 = (frm_cnt_q >= FRAME_BYTES_MAX) ? FRAME_BYTES_MAX : frm_cnt_q + CNT_W'(1);
		take_type = awaiting_q && (nal1 > SLOT_BYTES);
		is_aud = take_type && code_led_q && (byte_s1[TYPE_W-1:0] == TYPE_AUD);
		is_sps = take_type && code_led_q && (byte_s1[TYPE_W-1:0] == TYPE_SPS);
		fs_aud = (frm1 >= SLOT_BYTES + CNT_W'(1)) ? frm1 - (SLOT_BYTES + CNT_W'(1)) : '0;
		emit_aud = is_aud && (fs_aud != '0);
		if (is_aud) begin
			key1 = emit_aud ? 1'b0 : key_q;
		end else begin
			key1 = is_sps ? 1'b1 : key_q;
		end
		frm2 = is_aud ? SLOT_BYTES + CNT_W'(1) : frm1;
		type1 = take_type ? byte_s1[TYPE_W-1:0] : type_q;
		awaiting1 = take_type ? 1'b0 : awaiting_q;
	end

	// Start code detection
	always_comb begin
		is_sc = (win_q == '0) && (byte_s1 == SC_LAST_BYTE);
		emit_sc = is_sc && (frm2 != SLOT_BYTES);
		nl_sc = (nal1 >= SLOT_PAIR) ? nal1 - SLOT_PAIR : '0;
		nal2 = is_sc ? SLOT_BYTES : nal1;
		nl_eos = (nal2 >= SLOT_BYTES) ? nal2 - SLOT_BYTES : '0;
	end

	// Candidate results
	always_comb begin
		r_aud = '0;
		r_aud.event_kind = EV_FRAME;
		r_aud.frame_size = fs_aud;
		r_aud.is_key = key_q;

		r_sc = '0;
		r_sc.event_kind = EV_NAL;
		r_sc.nal_length = nl_sc;
		r_sc.unit_type = type1;

		r_eos_nal = '0;
		r_eos_nal.event_kind = EV_NAL;
		r_eos_nal.nal_length = nl_eos;
		r_eos_nal.unit_type = is_sc ? '0 : type1;

		r_eos_frm = '0;
		r_eos_frm.event_kind = EV_FRAME;
		r_eos_frm.frame_size = frm2;
		r_eos_frm.is_key = key1;
	end

	// Pack results in order; delimiter and start code never share a byte
	always_comb begin
		list = '0;
		k = '0;
		if (emit_aud || emit_sc) begin
			list[k] = emit_aud ? r_aud : r_sc;
			k = k + RES_CNT_W'(1);
		end
		if (eos_s1) begin
			list[k] = r_eos_nal;
			k = k + RES_CNT_W'(1);
			if (frm2 != '0) begin
				list[k] = r_eos_frm;
				k = k + RES_CNT_W'(1);
			end
		end
		for (int i = 0; i < RES_MAX; i++) begin
			list[i].last_of_run = (k != '0) && (RES_CNT_W'(i) == k - RES_CNT_W'(1));
		end
		push.cnt = valid_s1 ? k : '0;
		push.res = list;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_RESET;
			nal_cnt_q <= '0;
			frm_cnt_q <= '0;
			awaiting_q <= 1'b1;
			key_q <= 1'b0;
			type_q <= '0;
			code_led_q <= 1'b0;
		end else if (valid_s1) begin
			if (eos_s1) begin
				win_q <= WIN_RESET;
				nal_cnt_q <= '0;
				frm_cnt_q <= '0;
				awaiting_q <= 1'b1;
				key_q <= 1'b0;
				type_q <= '0;
				code_led_q <= 1'b0;
			end else begin
				frm_cnt_q <= frm2;
				nal_cnt_q <= nal2;
				key_q <= key1;
				if (is_sc) begin
					win_q <= WIN_RESET;
					awaiting_q <= 1'b1;
					type_q <= '0;
					code_led_q <= 1'b1;
				end else begin
					win_q <= {win_q[WIN_W-BYTE_W-1:0], byte_s1};
					awaiting_q <= awaiting1;
					type_q <= type1;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/anb_queue.sv
`default_nettype none

module anb_queue import anb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire anb_push_t push,
	input wire logic pop,
	output anb_result_t head,
	output logic [Q_CNT_W-1:0] count
);

	anb_result_t mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	// Storage; up to RES_MAX entries written per cycle
	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_MAX; i++) begin
			if (RES_CNT_W'(i) < push.cnt) begin
				mem_q[wr_ptr_q + Q_PTR_W'(i)] <= push.res[i];
			end
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			cnt_q <= cnt_q + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign count = cnt_q;

endmodule

`default_nettype wire

FILE: sv/annexb_nal_frame_splitter.sv
`default_nettype none

// Annex B NAL / frame boundary finder. Takes one stream byte per clock while
// input ready is high and reports NAL ends (payload length and type, for an
// AVCC length prefix) and frame ends (size and keyframe flag) at access unit
// delimiters and end of stream. A byte's results are formed from the input
// stage register and leave one per clock, while the output is ready, from an
// 8-entry result queue; a byte may cause up to three results. Input ready is
// held low while the queue holds more than two results, so the sustained rate
// is one byte per clock as long as results are taken as fast as they are made
// (at most one per byte on average), and otherwise follows the output side.
module annexb_nal_frame_splitter import anb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	anb_in_if.sink in_ch,
	anb_out_if.source out_ch
);

	anb_push_t push;
	anb_result_t head;
	logic [Q_CNT_W-1:0] q_count;
	logic in_fire, out_fire;

	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;

	// Leave room for the byte in flight and the one being accepted
	assign in_ch.ready = (q_count <= Q_CNT_W'(Q_ACCEPT_MAX));

	anb_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_fire),
		.data_byte(in_ch.data_byte),
		.end_of_stream(in_ch.end_of_stream),
		.push(push)
	);

	anb_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(out_fire),
		.head(head),
		.count(q_count)
	);

	// Result port
	assign out_ch.valid = (q_count != '0);
	assign out_ch.event_kind = head.event_kind;
	assign out_ch.nal_length = head.nal_length;
	assign out_ch.unit_type = head.unit_type;
	assign out_ch.frame_size = head.frame_size;
	assign out_ch.is_key = head.is_key;
	assign out_ch.last_of_run = head.last_of_run;

`ifndef ASSERT_OFF
	// Queue never overfills
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= Q_CNT_W'(Q_DEPTH))
		else $error("result queue overflow");

	// End of stream always flushes a NAL end and a frame end
	a_eos_flush: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_ch.end_of_stream |=> push.cnt >= RES_CNT_W'(2))
		else $error("end of stream without flush results");
`endif

endmodule

`default_nettype wire
